@@ design/epg_pkg.sv @@
package epg_pkg;

    // Radius inputs are masked to this many bits; the square, cross, decision and step widths follow from it.
    localparam int RADIUS_BITS = 12;

    localparam int RADIUS_IN_W = 12;
    localparam int COORD_W     = 16;
    localparam int SQ_W        = 2 * RADIUS_BITS;
    localparam int CROSS_W     = 3 * RADIUS_BITS;
    localparam int DEC_W       = 3 * RADIUS_BITS + 8;
    localparam int STEP_W      = RADIUS_BITS + 2;

    // Input word layout
    localparam int CX_LSB      = 0;
    localparam int CY_LSB      = CX_LSB + COORD_W;
    localparam int RX_LSB      = CY_LSB + COORD_W;
    localparam int RY_LSB      = RX_LSB + RADIUS_IN_W;
    localparam int IN_DATA_W   = ((RY_LSB + RADIUS_IN_W + 7) / 8) * 8;

    // Output word layout
    localparam int OUT_DATA_W  = 4 * COORD_W;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef logic [RADIUS_BITS-1:0] t_radius;

    typedef struct packed {
        logic               is_start;
        logic               radius_zero;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        t_radius            radius_x;
        t_radius            radius_y;
    } t_item;

endpackage

@@ design/epg_front.sv @@
module epg_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [epg_pkg::IN_DATA_W-1:0]   i_data,
    input  logic                            i_user,
    output logic                            o_valid,
    output epg_pkg::t_item                  o_item,
    input  logic                            i_pop
);

    epg_pkg::t_item r_mem [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_count;
    epg_pkg::t_item w_item;
    logic           w_push;
    logic           w_pop;

    // Classify the word and mask the radii before queueing
    always_comb begin
        w_item.is_start    = (i_user == epg_pkg::OP_START);
        w_item.center_x    = i_data[epg_pkg::CX_LSB +: epg_pkg::COORD_W];
        w_item.center_y    = i_data[epg_pkg::CY_LSB +: epg_pkg::COORD_W];
        w_item.radius_x    = epg_pkg::t_radius'(i_data[epg_pkg::RX_LSB +: epg_pkg::RADIUS_IN_W]);
        w_item.radius_y    = epg_pkg::t_radius'(i_data[epg_pkg::RY_LSB +: epg_pkg::RADIUS_IN_W]);
        w_item.radius_zero = (w_item.radius_x == '0) || (w_item.radius_y == '0);
    end

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_mem[r_wptr] <= w_item;
                r_wptr        <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ design/epg_walk.sv @@
module epg_walk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  epg_pkg::t_item                  i_item,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [epg_pkg::OUT_DATA_W-1:0]  o_data,
    output logic                            o_last
);

    localparam int RB = epg_pkg::RADIUS_BITS;
    localparam int SW = epg_pkg::SQ_W;
    localparam int CW = epg_pkg::CROSS_W;
    localparam int DW = epg_pkg::DEC_W;
    localparam int TW = epg_pkg::STEP_W;
    localparam int XW = epg_pkg::COORD_W;

    typedef enum logic [1:0] {
        S_RUN,
        S_SQUARE,
        S_CROSS,
        S_LOAD
    } t_state;

    t_state         r_state;
    logic           r_active;
    logic           r_out_valid;
    logic [epg_pkg::OUT_DATA_W-1:0] r_out_data;
    logic           r_out_last;

    logic [XW-1:0]  r_cx;
    logic [XW-1:0]  r_cy;
    logic [RB-1:0]  r_rx;
    logic [RB-1:0]  r_ry;
    logic [SW-1:0]  r_rxsq;
    logic [SW-1:0]  r_rysq;
    logic [CW-1:0]  r_cross;
    logic [SW-2:0]  r_qsum;
    logic [SW:0]    r_twice_rx;
    logic [SW:0]    r_twice_ry;
    logic [DW-1:0]  r_dec;
    logic [DW-1:0]  r_up_next;
    logic [DW-1:0]  r_in_next;
    logic [XW-1:0]  r_off_x;
    logic [XW-1:0]  r_off_y;
    logic [TW-1:0]  r_steps;

    logic           w_out_free;
    logic           w_emit;
    logic [SW:0]    w_sqsum;
    logic [XW-1:0]  w_right;
    logic [XW-1:0]  w_left;
    logic [XW-1:0]  w_upper;
    logic [XW-1:0]  w_lower;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_sqsum    = {1'b0, r_rxsq} + {1'b0, r_rysq};

    assign w_right = r_cx + r_off_x;
    assign w_left  = r_cx - r_off_x;
    assign w_upper = r_cy + r_off_y;
    assign w_lower = r_cy - r_off_y;

    always_comb begin
        o_pop  = 1'b0;
        w_emit = 1'b0;
        unique case (r_state)
            S_RUN: begin
                w_emit = i_valid && !i_item.is_start && r_active && w_out_free;
                // a step word while inactive is dropped without waiting on the output
                o_pop  = i_valid && (i_item.is_start || !r_active || w_out_free);
            end
            default: begin
                o_pop  = 1'b0;
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_RUN: begin
                    if (i_valid && i_item.is_start) begin
                        r_active <= 1'b0;
                        r_cx     <= i_item.center_x;
                        r_cy     <= i_item.center_y;
                        r_rx     <= i_item.radius_x;
                        r_ry     <= i_item.radius_y;
                        if (!i_item.radius_zero) begin
                            r_state <= S_SQUARE;
                        end
                    end else if (w_emit) begin
                        r_out_data <= {w_lower, w_upper, w_left, w_right};
                        r_out_last <= (r_steps == TW'(1));
                        if (r_dec[DW-1]) begin
                            // advance y
                            r_off_y   <= r_off_y + XW'(1);
                            r_dec     <= r_dec + r_up_next;
                            r_up_next <= r_up_next + DW'(r_twice_rx);
                        end else begin
                            // step x inward
                            r_off_x   <= r_off_x - XW'(1);
                            r_dec     <= r_dec - r_in_next;
                            r_in_next <= r_in_next - DW'(r_twice_ry);
                        end
                        r_steps <= r_steps - TW'(1);
                        if (r_steps == TW'(1)) begin
                            r_active <= 1'b0;
                        end
                    end
                end
                S_SQUARE: begin
                    r_rxsq  <= SW'(r_rx) * SW'(r_rx);
                    r_rysq  <= SW'(r_ry) * SW'(r_ry);
                    r_state <= S_CROSS;
                end
                S_CROSS: begin
                    r_cross    <= CW'(r_rx) * CW'(r_rysq);
                    r_qsum     <= w_sqsum[SW:2];
                    r_twice_rx <= {r_rxsq, 1'b0};
                    r_twice_ry <= {r_rysq, 1'b0};
                    r_state    <= S_LOAD;
                end
                S_LOAD: begin
                    r_dec     <= DW'(r_qsum) - DW'(r_cross);
                    // increments kept one move ahead so each step is a single add
                    r_up_next <= DW'(r_twice_rx);
                    r_in_next <= DW'({r_cross, 1'b0}) - DW'(r_twice_ry);
                    r_off_x   <= XW'(r_rx);
                    r_off_y   <= '0;
                    r_steps   <= TW'(r_rx) + TW'(r_ry) + TW'(1);
                    r_active  <= 1'b1;
                    r_state   <= S_RUN;
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

endmodule

@@ design/ellipse_point_generator_top.sv @@
// Channel   Dir  Handshake                Contents
// s_axis    in   tvalid/tready            tuser: opcode; tdata: center_x, center_y,
//                                         radius_x, radius_y
// m_axis    out  tvalid/tready            tdata: right_x, left_x, upper_y, lower_y;
//                                         tlast: last_point
//
// A step word leaves as one point set per cycle while an ellipse is being walked and the output is not stalled.
// A start word with both radii nonzero occupies the walker through the accept
// cycle, two registered multiply stages (squares, then rx * ry^2) and a load
// step for the decision terms; a zero-radius start stays in the run state.
// Synchronous active-low reset empties the two-word input queue, drops any walk
// in progress and clears the output valid.
// The input queue keeps taking words, up to its two entries, while a point set waits at the output.
module ellipse_point_generator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [15:0] center_x, [31:16] center_y, [43:32] radius_x, [55:44] radius_y
    input  logic [epg_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // [0] opcode
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [15:0] right_x, [31:16] left_x, [47:32] upper_y, [63:48] lower_y
    output logic [epg_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    output logic                            o_m_axis_tlast
);

    logic           w_q_valid;
    epg_pkg::t_item w_q_item;
    logic           w_q_pop;

    epg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .i_user  (i_s_axis_tuser),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    epg_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_item  (w_q_item),
        .o_pop   (w_q_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule
